/* rtl/core/csvft_pkg.sv */
// Shared types, constants and helpers of the CSV field tokenizer.
`default_nettype none
package csvft_pkg;

  localparam int PENDING_DEPTH = 16;
  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
  localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  localparam logic [7:0] SEP_RESET = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] field_byte;
    logic       byte_present;
    logic       field_end;
    logic       row_end;
    logic       stream_done;
    logic       overflow;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_MEM  = 2'd1,
    SEL_BYTE = 2'd2
  } emit_sel_t;

  typedef struct packed {
    logic      latch;
    logic      hold_cr;
    logic      hold_byte;
    logic      clear_field;
    logic      clear_count;
    logic      set_content;
    logic      set_cr;
    logic      clr_cr;
    logic      clr_row;
    logic      rd_start;
    logic      rd_issue;
    logic      rd_advance;
    logic      emit;
    emit_sel_t emit_sel;
    logic      fend;
    logic      rend;
    logic      sdone;
    logic      last;
    logic      ovf;
  } cmd_t;

  typedef struct packed {
    logic eos;
    logic is_sep;
    logic is_cr;
    logic is_lf;
    logic is_blank;
    logic saw_cr;
    logic has_content;
    logic row_started;
    logic count_zero;
    logic full;
    logic rd_last;
    logic ovf;
    logic out_free;
  } status_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF);
  endfunction

endpackage
`default_nettype wire

/* rtl/core/csvft_ctrl.sv */
// Sequencer of the CSV field tokenizer: steps one item through its actions.
`default_nettype none
module csvft_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire csvft_pkg::status_t st,
  output csvft_pkg::cmd_t        cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CR    = 6'b000010,
    S_MAIN  = 6'b000100,
    S_RD    = 6'b001000,
    S_OUT   = 6'b010000,
    S_LASTB = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   blank_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // overflow for a blank: already flagged, or the blank would be held into a full buffer
  assign blank_ovf = st.ovf | (st.has_content & st.full);

  always_comb begin
    cmd        = '0;
    cmd.emit_sel = csvft_pkg::SEL_NONE;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_CR;
        end
      end
      S_CR: begin
        if (st.saw_cr && !st.eos) begin
          if (st.is_lf) begin
            if (st.out_free) begin
              cmd.emit        = 1'b1;
              cmd.fend        = 1'b1;
              cmd.rend        = 1'b1;
              cmd.last        = 1'b1;
              cmd.ovf         = st.ovf;
              cmd.clear_field = 1'b1;
              cmd.clr_row     = 1'b1;
              cmd.clr_cr      = 1'b1;
              state_next      = S_IDLE;
            end
          end else begin
            cmd.hold_cr = 1'b1;
            cmd.clr_cr  = 1'b1;
            state_next  = S_MAIN;
          end
        end else begin
          state_next = S_MAIN;
        end
      end
      S_MAIN: begin
        if (st.eos) begin
          if (st.out_free) begin
            cmd.emit        = 1'b1;
            cmd.fend        = st.row_started;
            cmd.rend        = st.row_started;
            cmd.sdone       = 1'b1;
            cmd.last        = 1'b1;
            cmd.ovf         = st.ovf;
            cmd.clear_field = 1'b1;
            cmd.clr_cr      = 1'b1;
            cmd.clr_row     = 1'b1;
            state_next      = S_IDLE;
          end
        end else if (st.is_sep) begin
          if (st.out_free) begin
            cmd.emit        = 1'b1;
            cmd.fend        = 1'b1;
            cmd.last        = 1'b1;
            cmd.ovf         = st.ovf;
            cmd.clear_field = 1'b1;
            state_next      = S_IDLE;
          end
        end else if (st.is_cr) begin
          if (!st.ovf || st.out_free) begin
            cmd.set_cr = 1'b1;
            cmd.emit   = st.ovf;
            cmd.last   = 1'b1;
            cmd.ovf    = st.ovf;
            state_next = S_IDLE;
          end
        end else if (st.is_lf) begin
          if (st.out_free) begin
            cmd.emit        = 1'b1;
            cmd.fend        = 1'b1;
            cmd.rend        = 1'b1;
            cmd.last        = 1'b1;
            cmd.ovf         = st.ovf;
            cmd.clear_field = 1'b1;
            cmd.clr_row     = 1'b1;
            state_next      = S_IDLE;
          end
        end else if (st.is_blank) begin
          if (!blank_ovf || st.out_free) begin
            cmd.hold_byte = st.has_content;
            cmd.emit      = blank_ovf;
            cmd.last      = 1'b1;
            cmd.ovf       = blank_ovf;
            state_next    = S_IDLE;
          end
        end else if (st.count_zero) begin
          if (st.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_sel    = csvft_pkg::SEL_BYTE;
            cmd.last        = 1'b1;
            cmd.ovf         = st.ovf;
            cmd.set_content = 1'b1;
            state_next      = S_IDLE;
          end
        end else begin
          cmd.rd_start = 1'b1;
          state_next   = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_sel   = csvft_pkg::SEL_MEM;
          cmd.rd_advance = 1'b1;
          state_next     = st.rd_last ? S_LASTB : S_RD;
        end
      end
      S_LASTB: begin
        if (st.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_sel    = csvft_pkg::SEL_BYTE;
          cmd.last        = 1'b1;
          cmd.ovf         = st.ovf;
          cmd.clear_count = 1'b1;
          cmd.set_content = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/csvft_dp.sv */
// Datapath of the CSV field tokenizer: item, field state, pending buffer, result register.
`default_nettype none
module csvft_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire csvft_pkg::cmd_t     cmd,
  output csvft_pkg::status_t       st,
  input  wire csvft_pkg::in_item_t in_item,
  input  wire logic                cfg_valid,
  input  wire logic [7:0]          cfg_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output csvft_pkg::out_item_t     out_item
);

  logic [7:0]                  separator;
  logic [7:0]                  item_byte;
  logic                        item_eos;
  logic                        has_content;
  logic                        saw_cr;
  logic                        row_started;
  logic                        ovf;
  logic [csvft_pkg::CNT_W-1:0] count;
  logic [csvft_pkg::IDX_W-1:0] rd_idx;
  logic [7:0]                  mem_q;
  logic [7:0]                  mem [csvft_pkg::PENDING_DEPTH];
  logic                        full;
  logic                        do_hold;
  logic [7:0]                  hold_val;
  logic                        out_free;
  csvft_pkg::out_item_t        result;

  assign full     = (count == csvft_pkg::CNT_W'(csvft_pkg::PENDING_DEPTH));
  assign do_hold  = cmd.hold_cr | cmd.hold_byte;
  assign hold_val = cmd.hold_cr ? csvft_pkg::CH_CR : item_byte;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      separator   <= csvft_pkg::SEP_RESET;
      has_content <= 1'b0;
      saw_cr      <= 1'b0;
      row_started <= 1'b0;
      ovf         <= 1'b0;
      count       <= '0;
      rd_idx      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        separator <= cfg_data;
      end
      if (cmd.latch) begin
        ovf <= 1'b0;
        if (!in_item.end_of_stream) begin
          row_started <= 1'b1;
        end
      end
      if (do_hold) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          count <= count + csvft_pkg::CNT_W'(1);
        end
      end
      if (cmd.clear_field) begin
        has_content <= 1'b0;
        count       <= '0;
      end
      if (cmd.clear_count) begin
        count <= '0;
      end
      if (cmd.set_content) begin
        has_content <= 1'b1;
      end
      if (cmd.set_cr) begin
        saw_cr <= 1'b1;
      end
      if (cmd.clr_cr) begin
        saw_cr <= 1'b0;
      end
      if (cmd.clr_row) begin
        row_started <= 1'b0;
      end
      if (cmd.rd_start) begin
        rd_idx <= '0;
      end
      if (cmd.rd_advance) begin
        rd_idx <= rd_idx + csvft_pkg::IDX_W'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item and result payload: no reset needed
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_byte <= in_item.byte_value;
      item_eos  <= in_item.end_of_stream;
    end
    if (cmd.emit) begin
      out_item <= result;
    end
  end

  // pending whitespace buffer
  always_ff @(posedge clk) begin
    if (do_hold && !full) begin
      mem[count[csvft_pkg::IDX_W-1:0]] <= hold_val;
    end
    if (cmd.rd_issue) begin
      mem_q <= mem[rd_idx];
    end
  end

  always_comb begin
    result              = '0;
    result.field_end    = cmd.fend;
    result.row_end      = cmd.rend;
    result.stream_done  = cmd.sdone;
    result.overflow     = cmd.ovf;
    result.last         = cmd.last;
    case (cmd.emit_sel)
      csvft_pkg::SEL_MEM: begin
        result.field_byte   = mem_q;
        result.byte_present = 1'b1;
      end
      csvft_pkg::SEL_BYTE: begin
        result.field_byte   = item_byte;
        result.byte_present = 1'b1;
      end
      default: begin
        result.field_byte   = 8'h00;
        result.byte_present = 1'b0;
      end
    endcase
  end

  always_comb begin
    st.eos         = item_eos;
    st.is_sep      = (item_byte == separator);
    st.is_cr       = (item_byte == csvft_pkg::CH_CR);
    st.is_lf       = (item_byte == csvft_pkg::CH_LF);
    st.is_blank    = csvft_pkg::is_blank(item_byte);
    st.saw_cr      = saw_cr;
    st.has_content = has_content;
    st.row_started = row_started;
    st.count_zero  = (count == '0);
    st.full        = full;
    st.rd_last     = ((csvft_pkg::CNT_W'(rd_idx) + csvft_pkg::CNT_W'(1)) == count);
    st.ovf         = ovf;
    st.out_free    = out_free;
  end

endmodule
`default_nettype wire

/* rtl/core/csv_field_tokenizer.sv */
// Top level of the CSV field tokenizer: sequencer, datapath and handshake ports.
// Sequence: an item is latched in IDLE and its first result is registered from S_MAIN,
//   from S_CR for the LF of a CR+LF, or from S_OUT when held whitespace is released first.
//   A content byte that releases N held whitespace bytes does one pending-buffer read
//   (S_RD) and one result (S_OUT) per byte, then a result for the byte itself (S_LASTB);
//   a stalled output holds the sequencer in its state until the result register is free.
// Reset: rst (synchronous) clears all row state, empties the pending buffer count
//   and sets the separator to comma; buffer contents stay undefined, no clear pass.
`default_nettype none
module csv_field_tokenizer (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire csvft_pkg::in_item_t  in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output csvft_pkg::out_item_t      out_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [7:0]           cfg_data
);

  csvft_pkg::cmd_t    cmd;
  csvft_pkg::status_t st;

  // separator writes go straight into the separator register, so the config port never stalls
  assign cfg_ready = 1'b1;

  // sequencer: one item at a time, IDLE is the only state that takes an item
  csvft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath: item register, field flags, pending buffer and the result register,
  // which lets the next item in while a result is still waiting to be taken
  csvft_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // an accepted item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after accept");

  // end of stream always closes its item
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.stream_done |-> out_item.last)
    else $error("stream_done on a result that is not last");

  // overflow is only reported on the final result of an item
  a_ovf_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.overflow |-> out_item.last)
    else $error("overflow on a result that is not last");

  // a released field byte never ends the field in the same result
  a_byte_no_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.byte_present |-> !out_item.field_end && !out_item.stream_done)
    else $error("field byte combined with field end");

endmodule
`default_nettype wire
